@@ rtl/core/ddm_pkg.sv @@
// Shared constants and helper functions of the differential drive mixer.
`timescale 1ns / 1ps
`default_nettype none

package ddm_pkg;

  // Stream and configuration port widths
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Shared multiplier width (both operands)
  localparam int MUL_W  = 30;
  localparam int PROD_W = 2 * MUL_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_YAW_GAIN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_RATE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEDIUM_RATE = 2'd2;

  // Configuration reset values
  localparam logic [14:0] YAW_GAIN_RST    = 15'd9830;
  localparam logic [15:0] SLOW_RATE_RST   = 16'd427;
  localparam logic [15:0] MEDIUM_RATE_RST = 16'd853;

  // Pulse width thresholds in microseconds
  localparam logic [11:0] CENTRE_US   = 12'd1500;
  localparam logic [11:0] DEADZONE_US = 12'd30;
  localparam logic [11:0] NORM_SAT_US = 12'd500;
  localparam logic [11:0] SLOW_LIMIT  = 12'd1300;
  localparam logic [11:0] MED_LIMIT   = 12'd1700;
  localparam logic [11:0] FLIP_LIMIT  = 12'd1500;
  localparam logic [11:0] MAG_BASE    = 12'd1000;
  localparam logic [11:0] MAG_FLOOR   = 12'd1030;
  localparam logic [11:0] MAG_TOP     = 12'd2000;

  // Full scale in Q.15
  localparam logic [14:0] FS_MAX = 15'h7FFF;
  localparam logic [16:0] FS_ONE = 17'd32768;

  // Reciprocals: ceil(2^29/125), ceil(2^43/15625), ceil(2^28/1000)
  localparam logic [MUL_W-1:0] NORM_RECIP = 30'd4294968;
  localparam logic [MUL_W-1:0] STEP_RECIP = 30'd562949954;
  localparam logic [MUL_W-1:0] DUTY_RECIP = 30'd268436;

  // elapsed*rate at or above this saturates the slew step
  localparam logic [35:0] STEP_SAT_PROD = 36'd256000000;

  localparam logic [7:0]  DUTY_MAX   = 8'd255;
  localparam logic [10:0] PULSE_MID  = 11'd1500;
  localparam logic [10:0] PULSE_MIN  = 11'd1000;
  localparam logic [10:0] PULSE_MAX  = 11'd2000;
  localparam logic [23:0] HALF_SPAN  = 24'd500;

  // Distance of a pulse width from centre
  function automatic logic [11:0] abs_dev(input logic [11:0] us);
    return (us >= CENTRE_US) ? us - CENTRE_US : CENTRE_US - us;
  endfunction

  // Magnitude of a mixed motor value
  function automatic logic [16:0] abs18(input logic signed [17:0] v);
    return v[17] ? 17'(-v) : 17'(v);
  endfunction

  // Q.15 motor value (|v| <= 1.0) to ESC pulse width, truncating toward zero
  function automatic logic [10:0] to_pulse(input logic signed [17:0] v);
    logic [16:0] a;
    logic [23:0] sc;
    logic [8:0]  off;
    a   = abs18(v);
    sc  = 24'(a) * HALF_SPAN;
    off = sc[23:15];
    return v[17] ? PULSE_MID - 11'(off) : PULSE_MID + 11'(off);
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/differential_drive_mixer_top.sv @@
// Differential drive mixer: RC pulses in, ESC pulses and magnet duty out.
// Mixes that exceed full scale have both sides rescaled by the 16-step divider.
// One item is in flight at a time: a new item is accepted only in idle, after
//   the result is loaded; the single shared 30x30 multiplier is used once per
//   step and the divider produces one quotient bit per step.
// Reset: synchronous, active high; clears the sequencer, the output valid,
//   the slewed throttle and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module differential_drive_mixer_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // Input stream
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // tdata from bit 0: yaw_us[12], throttle_us[12], magnet_us[12],
  //   flip_us[12], traction_us[12], elapsed_us[20]
  input  wire logic [ddm_pkg::IN_DATA_W-1:0]  s_tdata,
  // tuser: link_ok[1]
  input  wire logic                           s_tuser,
  // Output stream
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // tdata from bit 0: left_pulse_us[11], right_pulse_us[11],
  //   magnet_duty[8], zero pad[2]
  output logic [ddm_pkg::OUT_DATA_W-1:0]      m_tdata,
  // Configuration write port
  input  wire logic                           cfg_we,
  input  wire logic [ddm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ddm_pkg::CFG_DATA_W-1:0] cfg_data
);

  import ddm_pkg::*;

  // Sequencer codes: from ST_NY1 to ST_ST2 each step issues one product to the shared
  // multiplier and, after the first, consumes the one issued in the step before.
  localparam logic [3:0] ST_IDLE = 4'd0;   // wait for an item
  localparam logic [3:0] ST_NY1  = 4'd1;   // yaw normalize product
  localparam logic [3:0] ST_NY2  = 4'd2;   // yaw square
  localparam logic [3:0] ST_CY1  = 4'd3;   // yaw cube
  localparam logic [3:0] ST_CY2  = 4'd4;   // yaw times yaw gain
  localparam logic [3:0] ST_YS   = 4'd5;   // take yaw, throttle normalize
  localparam logic [3:0] ST_NT2  = 4'd6;   // throttle square
  localparam logic [3:0] ST_CT1  = 4'd7;   // throttle cube
  localparam logic [3:0] ST_CT2  = 4'd8;   // take fwd, elapsed times rate
  localparam logic [3:0] ST_ST1  = 4'd9;   // step reciprocal product
  localparam logic [3:0] ST_ST2  = 4'd10;  // slew update, magnet product
  localparam logic [3:0] ST_MIX  = 4'd11;  // duty, mix, pick rescale
  localparam logic [3:0] ST_DIV  = 4'd12;  // rescale left then right
  localparam logic [3:0] ST_FIN  = 4'd13;  // load output register

  logic [3:0] state;

  // Configuration registers
  logic [14:0] yaw_gain;
  logic [15:0] slow_rate;
  logic [15:0] medium_rate;

  // Slewed throttle, the only state carried across items
  logic signed [15:0] throttle_now;

  // Latched item
  logic [11:0] yaw_us;
  logic [11:0] throttle_us;
  logic [11:0] magnet_us;
  logic [11:0] flip_us;
  logic [11:0] traction_us;
  logic [19:0] elapsed_us;
  logic        link_ok;

  // Shared multiplier
  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic [PROD_W-1:0] prod;

  // Working values
  logic [14:0]        mag;
  logic [14:0]        yaw_mag;
  logic               yaw_neg;
  logic signed [15:0] fwd;
  logic               step_sat;
  logic [7:0]         duty;
  logic signed [17:0] left;
  logic signed [17:0] right;

  // Divider
  logic [16:0] rem;
  logic [15:0] dq;
  logic [16:0] mx;
  logic [3:0]  div_cnt;
  logic        div_side;

  // Combinational helpers
  logic [11:0]        ad_y;
  logic [11:0]        ad_t;
  logic [11:0]        ad_sel;
  logic [14:0]        norm;
  logic [14:0]        cube;
  logic [15:0]        rate;
  logic [14:0]        step;
  logic signed [16:0] lim;
  logic [11:0]        mag_off;
  logic [17:0]        duty_n;
  logic [7:0]         duty_v;
  logic signed [17:0] cmd;
  logic signed [17:0] yaw_s;
  logic signed [17:0] left_c;
  logic signed [17:0] right_c;
  logic [16:0]        left_abs;
  logic [16:0]        right_abs;
  logic [16:0]        right_mag;
  logic [16:0]        mx_c;
  logic [17:0]        div_t;
  logic               div_ge;
  logic [15:0]        quot;
  logic signed [17:0] quot_s;
  logic               div_neg;
  logic signed [17:0] left_o;
  logic signed [17:0] right_o;

  assign s_tready = (state == ST_IDLE);

  // Centre distance, deadzone and saturation of the normalized value
  assign ad_y   = abs_dev(yaw_us);
  assign ad_t   = abs_dev(throttle_us);
  assign ad_sel = (state == ST_NY2) ? ad_y : ad_t;
  assign norm   = (ad_sel <= DEADZONE_US) ? '0 :
                  (ad_sel >= NORM_SAT_US) ? FS_MAX : prod[30:16];
  assign cube   = prod[44:30];

  // Slew step: saturate when elapsed*rate reaches full scale
  assign rate = (traction_us < SLOW_LIMIT) ? slow_rate : medium_rate;
  assign step = step_sat ? FS_MAX : prod[56:42];
  assign lim  = 17'(throttle_now) + $signed({2'b00, step});

  // Magnet duty: (mag-1000)*255/1000 through a reciprocal
  assign mag_off = magnet_us - MAG_BASE;
  assign duty_n  = {mag_off[9:0], 8'd0} - {8'd0, mag_off[9:0]};
  assign duty_v  = (magnet_us <= MAG_FLOOR) ? '0 :
                   (magnet_us >= MAG_TOP)   ? DUTY_MAX : prod[35:28];

  // Mix
  assign cmd       = (flip_us < FLIP_LIMIT) ? -18'(throttle_now) : 18'(throttle_now);
  assign yaw_s     = yaw_neg ? -$signed({3'b000, yaw_mag}) : $signed({3'b000, yaw_mag});
  assign left_c    = cmd + yaw_s;
  assign right_c   = cmd - yaw_s;
  assign left_abs  = abs18(left_c);
  assign right_abs = abs18(right_c);
  assign mx_c      = (left_abs > right_abs) ? left_abs : right_abs;

  // Magnitude of the stored right value, loaded after the left quotient
  assign right_mag = abs18(right);

  // One restoring division step: remainder and next dividend bit
  assign div_t   = {rem, dq[15]};
  assign div_ge  = (div_t >= {1'b0, mx});
  assign quot    = {dq[14:0], div_ge};
  assign div_neg = div_side ? right[17] : left[17];
  assign quot_s  = div_neg ? -$signed({2'b00, quot}) : $signed({2'b00, quot});

  // Failsafe zeroes both motors
  assign left_o  = link_ok ? left  : '0;
  assign right_o = link_ok ? right : '0;

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_NY1: begin
        mul_a = MUL_W'(ad_y[8:0]);
        mul_b = NORM_RECIP;
      end
      ST_NY2, ST_NT2: begin
        mul_a = MUL_W'(norm);
        mul_b = MUL_W'(norm);
      end
      ST_CY1, ST_CT1: begin
        mul_a = prod[29:0];
        mul_b = MUL_W'(mag);
      end
      ST_CY2: begin
        mul_a = MUL_W'(cube);
        mul_b = MUL_W'(yaw_gain);
      end
      ST_YS: begin
        mul_a = MUL_W'(ad_t[8:0]);
        mul_b = NORM_RECIP;
      end
      ST_CT2: begin
        mul_a = MUL_W'(elapsed_us);
        mul_b = MUL_W'(rate);
      end
      ST_ST1: begin
        mul_a = MUL_W'(prod[27:0]);
        mul_b = STEP_RECIP;
      end
      ST_ST2: begin
        mul_a = MUL_W'(duty_n);
        mul_b = DUTY_RECIP;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Control: sequencer, configuration, slewed throttle, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      m_tvalid     <= 1'b0;
      throttle_now <= '0;
      yaw_gain     <= YAW_GAIN_RST;
      slow_rate    <= SLOW_RATE_RST;
      medium_rate  <= MEDIUM_RATE_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_YAW_GAIN:    yaw_gain    <= cfg_data[14:0];
          REG_SLOW_RATE:   slow_rate   <= cfg_data;
          REG_MEDIUM_RATE: medium_rate <= cfg_data;
          default: ;
        endcase
      end

      // Raise valid when a result is loaded, drop it once taken
      if (state == ST_FIN && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_NY1;
          end
        end
        ST_NY1: state <= ST_NY2;
        ST_NY2: state <= ST_CY1;
        ST_CY1: state <= ST_CY2;
        ST_CY2: state <= ST_YS;
        ST_YS:  state <= ST_NT2;
        ST_NT2: state <= ST_CT1;
        ST_CT1: state <= ST_CT2;
        ST_CT2: state <= ST_ST1;
        ST_ST1: state <= ST_ST2;
        ST_ST2: begin
          // Negative state or immediate mode follows at once; else limit rise
          if (throttle_now[15] || traction_us >= MED_LIMIT) begin
            throttle_now <= fwd;
          end else if (17'(fwd) < lim) begin
            throttle_now <= fwd;
          end else begin
            throttle_now <= lim[15:0];
          end
          state <= ST_MIX;
        end
        ST_MIX: begin
          state <= (mx_c > FS_ONE) ? ST_DIV : ST_FIN;
        end
        ST_DIV: begin
          if (div_cnt == 4'd15 && div_side) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          // Hold here while the previous result waits
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a) * PROD_W'(mul_b);

    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          yaw_us      <= s_tdata[11:0];
          throttle_us <= s_tdata[23:12];
          magnet_us   <= s_tdata[35:24];
          flip_us     <= s_tdata[47:36];
          traction_us <= s_tdata[59:48];
          elapsed_us  <= s_tdata[79:60];
          link_ok     <= s_tuser;
        end
      end
      ST_NY2, ST_NT2: begin
        mag <= norm;
      end
      ST_CY2: begin
        yaw_neg <= (yaw_us < CENTRE_US);
      end
      ST_YS: begin
        yaw_mag <= prod[29:15];
      end
      ST_CT2: begin
        fwd <= (throttle_us < CENTRE_US) ? -$signed({1'b0, cube}) : $signed({1'b0, cube});
      end
      ST_ST1: begin
        step_sat <= (prod[35:0] >= STEP_SAT_PROD);
      end
      ST_MIX: begin
        duty     <= duty_v;
        left     <= left_c;
        right    <= right_c;
        mx       <= mx_c;
        // Dividend |left| << 15 split as upper bits and the 16 bits to shift in
        rem      <= {1'b0, left_abs[16:1]};
        dq       <= {left_abs[0], 15'd0};
        div_cnt  <= '0;
        div_side <= 1'b0;
      end
      ST_DIV: begin
        div_cnt <= div_cnt + 4'd1;
        if (div_cnt == 4'd15 && !div_side) begin
          // Store the left quotient and start on the right side
          left     <= quot_s;
          rem      <= {1'b0, right_mag[16:1]};
          dq       <= {right_mag[0], 15'd0};
          div_side <= 1'b1;
        end else begin
          rem <= div_ge ? 17'(div_t - {1'b0, mx}) : div_t[16:0];
          dq  <= quot;
          if (div_cnt == 4'd15) begin
            right <= quot_s;
          end
        end
      end
      ST_FIN: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= {2'b00, (link_ok ? duty : 8'd0), to_pulse(right_o), to_pulse(-left_o)};
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // The sequencer takes no second item straight after an accept
  ap_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while an item is in progress");

  // Rescaling only runs when the mix exceeds full scale
  ap_div_needed: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (mx > FS_ONE))
    else $error("divider running on an in-range mix");

  // Both ESC pulses stay within the servo range
  ap_pulse_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[10:0] >= PULSE_MIN && m_tdata[10:0] <= PULSE_MAX &&
                  m_tdata[21:11] >= PULSE_MIN && m_tdata[21:11] <= PULSE_MAX))
    else $error("ESC pulse out of range");
`endif

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for differential_drive_mixer_top with a built-in mixer predictor.
`timescale 1ns / 1ps

module testbench;

  import ddm_pkg::*;

  // One control tick as offered on the input stream
  typedef struct packed {
    logic [11:0] yaw;
    logic [11:0] thr;
    logic [11:0] mag;
    logic [11:0] flip;
    logic [11:0] trac;
    logic [19:0] elapsed;
    logic        link;
  } tick_t;

  // One mixer result as seen on the output stream
  typedef struct packed {
    logic [10:0] left_us;
    logic [10:0] right_us;
    logic [7:0]  duty;
  } motor_out_t;

  // Directed row: typed set means the result is written in the row itself
  typedef struct packed {
    tick_t      tick;
    logic       typed;
    motor_out_t want;
  } dir_row_t;

  localparam int    CYCLE_LIMIT   = 400000;
  localparam int    DRAIN_CYCLES  = 60;     // idle margin at the end of the run
  localparam int    LONG_HOLD     = 400;
  localparam int    PHASE_TICKS   = 100;
  localparam int    NUM_PHASES    = 6;
  localparam longint Q_ONE        = 32768;
  localparam longint Q_MAX        = 32767;
  localparam longint MID_US       = 1500;
  localparam longint DEAD_US      = 30;
  localparam longint SPAN_US      = 500;
  localparam longint SLOW_BELOW   = 1300;
  localparam longint MED_BELOW    = 1700;
  localparam longint FLIP_BELOW   = 1500;
  localparam longint MAG_ZERO_US  = 1000;
  localparam longint MAG_FULL_US  = 2000;
  localparam longint US_PER_SEC   = 1000000;

  // Directed ticks: reset state, deadzone edges, magnet floor and ceiling,
  // out-of-range pulses, every traction band, flip edge, rescale, link loss.
  localparam int NUM_DIRECTED = 21;
  localparam dir_row_t DIRECTED [0:NUM_DIRECTED-1] = '{
    '{'{12'd1500, 12'd1500, 12'd1000, 12'd2000, 12'd2000, 20'd0,       1'b1}, 1'b1,
      '{11'd1500, 11'd1500, 8'd0}},
    '{'{12'd1500, 12'd1500, 12'd1030, 12'd2000, 12'd2000, 20'd1000,    1'b1}, 1'b1,
      '{11'd1500, 11'd1500, 8'd0}},
    '{'{12'd1470, 12'd1530, 12'd1031, 12'd2000, 12'd2000, 20'd1000,    1'b1}, 1'b1,
      '{11'd1500, 11'd1500, 8'd7}},
    '{'{12'd1530, 12'd1470, 12'd2000, 12'd1000, 12'd1000, 20'd1000,    1'b1}, 1'b1,
      '{11'd1500, 11'd1500, 8'd255}},
    '{'{12'd1500, 12'd1500, 12'd4095, 12'd4095, 12'd4095, 20'd20,      1'b1}, 1'b1,
      '{11'd1500, 11'd1500, 8'd255}},
    '{'{12'd1469, 12'd1500, 12'd1500, 12'd2000, 12'd2000, 20'd100,     1'b1}, 1'b0, '0},
    '{'{12'd1531, 12'd1500, 12'd1500, 12'd2000, 12'd2000, 20'd100,     1'b1}, 1'b0, '0},
    '{'{12'd1500, 12'd4095, 12'd1500, 12'd2000, 12'd2000, 20'd0,       1'b1}, 1'b0, '0},
    '{'{12'd1500, 12'd0,    12'd1500, 12'd2000, 12'd1000, 20'd10000,   1'b1}, 1'b0, '0},
    '{'{12'd1500, 12'd4095, 12'd1500, 12'd2000, 12'd1000, 20'd10000,   1'b1}, 1'b0, '0},
    '{'{12'd1500, 12'd1500, 12'd1500, 12'd2000, 12'd1299, 20'd20000,   1'b1}, 1'b0, '0},
    '{'{12'd1500, 12'd2000, 12'd1500, 12'd2000, 12'd1299, 20'd20000,   1'b1}, 1'b0, '0},
    '{'{12'd1500, 12'd2000, 12'd1500, 12'd2000, 12'd1300, 20'hFFFFF,   1'b1}, 1'b0, '0},
    '{'{12'd1500, 12'd1800, 12'd1500, 12'd1499, 12'd1699, 20'd5000,    1'b1}, 1'b0, '0},
    '{'{12'd1500, 12'd1800, 12'd1500, 12'd1500, 12'd1700, 20'd5000,    1'b1}, 1'b0, '0},
    '{'{12'd4095, 12'd4095, 12'd1500, 12'd2000, 12'd2000, 20'd1000,    1'b1}, 1'b0, '0},
    '{'{12'd0,    12'd4095, 12'd1500, 12'd2000, 12'd2000, 20'd1000,    1'b1}, 1'b0, '0},
    '{'{12'd0,    12'd0,    12'd0,    12'd0,    12'd0,    20'd0,       1'b1}, 1'b0, '0},
    '{'{12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 20'hFFFFF,   1'b0}, 1'b1,
      '{11'd1500, 11'd1500, 8'd0}},
    '{'{12'd0,    12'd0,    12'd0,    12'd0,    12'd0,    20'd0,       1'b0}, 1'b1,
      '{11'd1500, 11'd1500, 8'd0}},
    '{'{12'd2000, 12'd1000, 12'd1700, 12'd1000, 12'd1700, 20'd500,     1'b1}, 1'b0, '0}
  };

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Predictor copy of the registers and the slewed throttle
  longint turn_gain;
  longint slow_rate_q;
  longint med_rate_q;
  longint throttle_held;

  motor_out_t pending_mix[$];

  int  mismatches;
  int  results_seen;
  int  ticks_sent;
  int  settings_used;
  int  cycle_count;
  bit  tx_idle_en;
  bit  rx_idle_en;
  bit  hold_req;

  differential_drive_mixer_top u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Pulse width to signed Q.15 with centre deadzone and saturation
  function automatic longint centre_norm(input logic [11:0] us);
    longint d;
    d = longint'(us) - MID_US;
    if (d >= -DEAD_US && d <= DEAD_US) return 0;
    d = (d * Q_ONE) / SPAN_US;
    if (d > Q_MAX) d = Q_MAX;
    else if (d < -Q_MAX) d = -Q_MAX;
    return d;
  endfunction

  // Sign-magnitude cube, truncating the magnitude
  function automatic longint cube_q15(input longint v);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m * m * m) >> 30;
    return (v < 0) ? -m : m;
  endfunction

  function automatic logic [10:0] esc_pulse(input longint v);
    longint c;
    c = (v > Q_ONE) ? Q_ONE : ((v < -Q_ONE) ? -Q_ONE : v);
    return 11'(MID_US + (c * SPAN_US) / Q_ONE);
  endfunction

  // Work out one tick's result and advance the slewed throttle
  function automatic motor_out_t mix_predict(input tick_t t);
    motor_out_t r;
    longint yc, ys, yaw_cmd, fwd, rate, slew_inc, lim, cmd;
    longint left_m, right_m, ml, mr, mx, duty;
    yc      = cube_q15(centre_norm(t.yaw));
    ys      = (((yc < 0) ? -yc : yc) * turn_gain) >> 15;
    yaw_cmd = (yc < 0) ? -ys : ys;
    fwd     = cube_q15(centre_norm(t.thr));

    // Rise is rate limited only from a non-negative throttle and below the top band
    if (throttle_held < 0 || longint'(t.trac) >= MED_BELOW) begin
      throttle_held = fwd;
    end else begin
      rate     = (longint'(t.trac) < SLOW_BELOW) ? slow_rate_q : med_rate_q;
      slew_inc = (longint'(t.elapsed) * rate * 128) / US_PER_SEC;
      if (slew_inc > Q_MAX) slew_inc = Q_MAX;
      lim           = throttle_held + slew_inc;
      throttle_held = (fwd < lim) ? fwd : lim;
    end

    cmd     = (longint'(t.flip) < FLIP_BELOW) ? -throttle_held : throttle_held;
    left_m  = cmd + yaw_cmd;
    right_m = cmd - yaw_cmd;
    ml      = (left_m < 0) ? -left_m : left_m;
    mr      = (right_m < 0) ? -right_m : right_m;
    mx      = (ml > mr) ? ml : mr;
    // Keep the left/right ratio when either side runs past full scale
    if (mx > Q_ONE) begin
      left_m  = (left_m * Q_ONE) / mx;
      right_m = (right_m * Q_ONE) / mx;
    end

    if (longint'(t.mag) <= MAG_ZERO_US + DEAD_US) duty = 0;
    else if (longint'(t.mag) >= MAG_FULL_US) duty = 255;
    else duty = ((longint'(t.mag) - MAG_ZERO_US) * 255) / (MAG_FULL_US - MAG_ZERO_US);

    // Failsafe: motors to neutral, magnet off, throttle state kept as updated
    if (!t.link) begin
      left_m  = 0;
      right_m = 0;
      duty    = 0;
    end

    r.left_us  = esc_pulse(-left_m);
    r.right_us = esc_pulse(right_m);
    r.duty     = 8'(duty);
    return r;
  endfunction

  function automatic logic [11:0] rand_pulse();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 12'($urandom_range(0, 4095));
    if (sel == 1) return 12'($urandom_range(1460, 1540));
    return 12'($urandom_range(950, 2050));
  endfunction

  // Mostly plausible RC frames, with some wild pulses and link drops
  function automatic tick_t rand_tick();
    tick_t t;
    int    sel;
    t.yaw  = rand_pulse();
    t.thr  = rand_pulse();
    t.mag  = rand_pulse();
    sel    = $urandom_range(0, 9);
    t.flip = (sel < 4) ? 12'd1000 : ((sel < 8) ? 12'd2000 : 12'($urandom_range(0, 4095)));
    sel    = $urandom_range(0, 9);
    case (sel)
      0, 1, 2: t.trac = 12'($urandom_range(1000, 1299));
      3, 4, 5: t.trac = 12'($urandom_range(1300, 1699));
      6, 7, 8: t.trac = 12'($urandom_range(1700, 2100));
      default: t.trac = 12'($urandom_range(0, 4095));
    endcase
    sel = $urandom_range(0, 9);
    if (sel < 7) t.elapsed = 20'($urandom_range(0, 30000));
    else if (sel < 9) t.elapsed = 20'($urandom_range(0, 300000));
    else t.elapsed = 20'($urandom_range(0, 20'hFFFFF));
    t.link = ($urandom_range(0, 15) != 0);
    return t;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at result %0d: %s", results_seen, msg);
    mismatches++;
  endtask

  // Offer one tick, hold it until taken, then queue its expected result
  task automatic send_tick(input tick_t t, input logic typed, input motor_out_t want);
    motor_out_t pred;
    int         gap;
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {t.elapsed, t.trac, t.flip, t.mag, t.thr, t.yaw};
    s_tuser  <= t.link;
    do @(posedge clk); while (!s_tready);
    pred = mix_predict(t);
    pending_mix.push_back(typed ? want : pred);
    ticks_sent++;
  endtask

  // Drop valid and wait until every queued result has come back
  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_mix.size() != 0) @(posedge clk);
  endtask

  // Write all three registers while the block is idle
  task automatic write_regs(input logic [15:0] mt, input logic [15:0] sr,
                            input logic [15:0] mr);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_YAW_GAIN;
    cfg_data  <= mt;
    @(negedge clk);
    cfg_index <= REG_SLOW_RATE;
    cfg_data  <= sr;
    @(negedge clk);
    cfg_index <= REG_MEDIUM_RATE;
    cfg_data  <= mr;
    @(negedge clk);
    cfg_we    <= 1'b0;
    turn_gain   = longint'(mt[14:0]);
    slow_rate_q = longint'(sr);
    med_rate_q  = longint'(mr);
    settings_used++;
  endtask

  // Result checker: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    motor_out_t got;
    motor_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.left_us  = m_tdata[10:0];
      got.right_us = m_tdata[21:11];
      got.duty     = m_tdata[29:22];
      if (pending_mix.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", got));
      end else begin
        want = pending_mix.pop_front();
        if (got.left_us !== want.left_us)
          report_mismatch($sformatf("left_pulse_us %0d, want %0d", got.left_us, want.left_us));
        if (got.right_us !== want.right_us)
          report_mismatch($sformatf("right_pulse_us %0d, want %0d",
                                    got.right_us, want.right_us));
        if (got.duty !== want.duty)
          report_mismatch($sformatf("magnet_duty %0d, want %0d", got.duty, want.duty));
      end
      results_seen++;
    end
  end

  // Watchdog: stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_mix.size());
      $display("differential_drive_mixer_top test failed");
      $finish;
    end
  end

  // Output side: random stall bursts, plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    m_tready   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = LONG_HOLD - 1;
        m_tready  <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(0, 5);
        m_tready  <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Main sequence: reset, directed table, then random phases, most under new settings
  initial begin
    int i;
    int ph;
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_YAW_GAIN;
    cfg_data      = '0;
    mismatches    = 0;
    results_seen  = 0;
    ticks_sent    = 0;
    settings_used = 1;
    cycle_count   = 0;
    tx_idle_en    = 1'b1;
    rx_idle_en    = 1'b1;
    hold_req      = 1'b0;
    turn_gain     = longint'(YAW_GAIN_RST);
    slow_rate_q   = longint'(SLOW_RATE_RST);
    med_rate_q    = longint'(MEDIUM_RATE_RST);
    throttle_held = 0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < NUM_DIRECTED; i++)
      send_tick(DIRECTED[i].tick, DIRECTED[i].typed, DIRECTED[i].want);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      drain_results();
      case (ph)
        1: write_regs(16'd0, 16'd0, 16'd0);
        2: write_regs(16'h7FFF, 16'hFFFF, 16'hFFFF);
        3: write_regs(16'($urandom), 16'($urandom), 16'($urandom));
        4: write_regs(16'($urandom), 16'($urandom_range(0, 2000)),
                      16'($urandom_range(0, 4000)));
        5: write_regs(16'(YAW_GAIN_RST), SLOW_RATE_RST, MEDIUM_RATE_RST);
        default: ;
      endcase
      // Run one phase clean, and keep the tail of the run free of idling
      tx_idle_en = (ph != 1 && ph != NUM_PHASES - 1);
      rx_idle_en = tx_idle_en;
      // Back up the block: hold the output while ticks keep coming
      if (ph == 2) hold_req = 1'b1;
      for (i = 0; i < PHASE_TICKS; i++) begin
        // Let the pipeline run dry once in the middle of a phase
        if (ph == 4 && i == PHASE_TICKS / 2) drain_results();
        send_tick(rand_tick(), 1'b0, '0);
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d ticks under %0d register settings, %0d results checked.",
             ticks_sent, settings_used, results_seen);
    $display("Covered deadzone edges, all traction bands, flip, rescaled mixes, link loss.");
    if (mismatches == 0 && pending_mix.size() == 0) begin
      $display("differential_drive_mixer_top test passed");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_mix.size());
      $display("differential_drive_mixer_top test failed");
    end
    $finish;
  end

endmodule

@@ differential_drive_mixer_top.f @@
rtl/core/ddm_pkg.sv
rtl/core/differential_drive_mixer_top.sv
sim/testbench.sv
